>>> hw/rtl/lba_pkg.sv
package lba_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int WEIGHT_W  = 16;
    localparam int GP_W      = 10;
    localparam int RIDX_W    = 9;
    localparam int ACC_W     = 48;
    localparam int AMT_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_START      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS     = 2'd2;

    localparam logic signed [CFG_W-1:0] GRID_START_RST      = 32'sd0;
    localparam logic [CFG_W-1:0]        INVERSE_SPACING_RST = 32'd65536;
    localparam logic [GP_W-1:0]         GRID_POINTS_RST     = 10'd401;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic [WEIGHT_W-1:0]        sample_weight;
        logic                       is_infinite;
        logic [RIDX_W-1:0]          read_index;
    } t_in_item;

    typedef struct packed {
        logic [ACC_W-1:0] bin_total;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_HEAD,
        OP_PAIR,
        OP_TAIL
    } t_bin_op;

    typedef struct packed {
        logic    done;
        t_bin_op op;
    } t_pos_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POS,
        S_W0,
        S_W1,
        S_RADDR,
        S_RDATA
    } t_state;

endpackage

>>> hw/rtl/lba_if.sv
interface lba_in_if import lba_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lba_out_if import lba_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/lba_bank.sv
module lba_bank import lba_pkg::*; #(
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [ACC_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [ACC_W-1:0] i_wr_data
);

    logic [ACC_W-1:0] r_mem [DEPTH];
    logic [ACC_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/lba_pos.sv
module lba_pos import lba_pkg::*; #(
    parameter int MAX_GRID = 512,
    localparam int IW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [WEIGHT_W-1:0]        i_weight,
    input  logic                       i_drop,
    input  logic signed [CFG_W-1:0]    i_grid_start,
    input  logic [CFG_W-1:0]           i_inverse_spacing,
    input  logic [GP_W-1:0]            i_grid_points,
    output t_pos_status                o_status,
    output logic [IW-1:0]              o_idx,
    output logic [AMT_W-1:0]           o_amt_lead,
    output logic [AMT_W-1:0]           o_amt_next
);

    localparam logic [GP_W:0] GP_CAP = (MAX_GRID >= (1 << GP_W)) ?
                                       {1'b0, {GP_W{1'b1}}} : (GP_W+1)'(MAX_GRID);

    logic r1_v, r2_v, r3_v, r4_v, r5_v;

    logic [32:0]         r1_mag;
    logic                r1_neg, r1_drop;
    logic [WEIGHT_W-1:0] r1_w;
    logic [47:0]         r2_phi, r2_plo;
    logic                r2_neg, r2_drop;
    logic [WEIGHT_W-1:0] r2_w;
    logic [63:0]         r3_prod;
    logic                r3_neg, r3_drop;
    logic [WEIGHT_W-1:0] r3_w;
    t_bin_op             r4_op;
    logic [IW-1:0]       r4_idx;
    logic [15:0]         r4_frac;
    logic [WEIGHT_W-1:0] r4_w;
    t_bin_op             r5_op;
    logic [IW-1:0]       r5_idx;
    logic [AMT_W-1:0]    r5_amt_lead, r5_amt_next;

    logic signed [32:0] x_ext, g_ext;
    logic               n1_neg;
    logic [32:0]        n1_mag;
    logic [48:0]        p_hi;
    logic [47:0]        p_lo;
    logic [63:0]        n3_prod;
    logic [GP_W-1:0]    m;
    logic [31:0]        idx, nlow;
    logic               over, pz;
    t_bin_op            n4_op;
    logic [IW-1:0]      n4_idx;
    logic [15:0]        n4_frac;
    logic [AMT_W-1:0]   amt_lo, amt_hi;

    always_comb begin
        x_ext  = {i_sample[SAMPLE_W-1], i_sample};
        g_ext  = {i_grid_start[CFG_W-1], i_grid_start};
        n1_neg = i_sample < i_grid_start;
        n1_mag = n1_neg ? 33'(g_ext - x_ext) : 33'(x_ext - g_ext);
    end

    // magnitude never exceeds 2^32, so the top bit of p_hi stays clear
    always_comb begin
        p_hi = {32'b0, r1_mag[32:16]} * {17'b0, i_inverse_spacing};
        p_lo = {32'b0, r1_mag[15:0]} * {16'b0, i_inverse_spacing};
    end

    assign n3_prod = {r2_phi, 16'b0} + {16'b0, r2_plo};

    always_comb begin
        m    = ({1'b0, i_grid_points} > GP_CAP) ? GP_CAP[GP_W-1:0] : i_grid_points;
        idx  = r3_prod[63:32];
        nlow = 32'd0 - r3_prod[31:0];
        pz   = (r3_prod == 64'd0);
        over = (r3_prod[63:33] != 31'd0) || (r3_prod[32] && (r3_prod[31:0] != 32'd0));
        n4_idx  = IW'(idx);
        n4_frac = r3_prod[31:16];
        priority if (r3_drop || (m == '0)) begin
            n4_op = OP_NONE;
        end else if (r3_neg && !pz) begin
            n4_op   = over ? OP_NONE : OP_HEAD;
            n4_idx  = '0;
            n4_frac = nlow[31:16];
        end else if (({1'b0, idx} + 33'd2) <= {{(33-GP_W){1'b0}}, m}) begin
            n4_op = OP_PAIR;
        end else if (({1'b0, idx} + 33'd1) == {{(33-GP_W){1'b0}}, m}) begin
            n4_op = OP_TAIL;
        end else begin
            n4_op = OP_NONE;
        end
    end

    always_comb begin
        amt_lo = {16'b0, r4_w} * (32'h0001_0000 - {16'b0, r4_frac});
        amt_hi = {16'b0, r4_w} * {16'b0, r4_frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_start;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r1_mag  <= n1_mag;
            r1_neg  <= n1_neg;
            r1_drop <= i_drop;
            r1_w    <= i_weight;
        end
        if (r1_v) begin
            r2_phi  <= p_hi[47:0];
            r2_plo  <= p_lo;
            r2_neg  <= r1_neg;
            r2_drop <= r1_drop;
            r2_w    <= r1_w;
        end
        if (r2_v) begin
            r3_prod <= n3_prod;
            r3_neg  <= r2_neg;
            r3_drop <= r2_drop;
            r3_w    <= r2_w;
        end
        if (r3_v) begin
            r4_op   <= n4_op;
            r4_idx  <= n4_idx;
            r4_frac <= n4_frac;
            r4_w    <= r3_w;
        end
        if (r4_v) begin
            r5_op       <= r4_op;
            r5_idx      <= r4_idx;
            r5_amt_lead <= (r4_op == OP_HEAD) ? amt_hi : amt_lo;
            r5_amt_next <= amt_hi;
        end
    end

    assign o_status.done = r5_v;
    assign o_status.op   = r5_op;
    assign o_idx         = r5_idx;
    assign o_amt_lead    = r5_amt_lead;
    assign o_amt_next    = r5_amt_next;

endmodule

>>> hw/rtl/linear_binning_accumulator_core.sv
// Sample beat: the next beat is taken once the five-stage position pipe has finished and
//   one read-modify-write slot per touched bin has run on the bin memory.
// Read beat: the bin is read once the output slot is free, then registered in S_RDATA
//   before the next beat is taken; the read waits while the output holds the last result.
// Reset: synchronous, active low; state and config registers return to defaults, then a
//   clearing pass zeroes all MAX_GRID bins, input held off; config writes are still taken.
module linear_binning_accumulator_core import lba_pkg::*; #(
    parameter int MAX_GRID = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lba_in_if.sink               i_in,
    lba_out_if.source            o_out,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wr_data
);

    localparam int IW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam logic [IW-1:0] CLR_LAST = IW'(MAX_GRID - 1);
    localparam logic [RIDX_W:0] RD_LIMIT = (MAX_GRID >= (1 << RIDX_W)) ?
                                           (RIDX_W+1)'(1 << RIDX_W) : (RIDX_W+1)'(MAX_GRID);

    t_state                   r_state, n_state;
    logic [IW-1:0]            r_clr;
    logic signed [CFG_W-1:0]  r_grid_start;
    logic [CFG_W-1:0]         r_inverse_spacing;
    logic [GP_W-1:0]          r_grid_points;
    logic [RIDX_W-1:0]        r_read_index;
    logic                     r_out_valid, n_out_valid;
    logic [ACC_W-1:0]         r_out_data;

    logic                     in_beat, pos_start, in_range, out_load;
    t_pos_status              pos_st;
    logic [IW-1:0]            pos_idx, pos_idx_next;
    logic [AMT_W-1:0]         amt_lead, amt_next, amt_sel;
    logic                     mem_rd_en, mem_wr_en;
    logic [IW-1:0]            mem_rd_addr, mem_wr_addr;
    logic [ACC_W-1:0]         mem_rd_data, mem_wr_data, sat_sum;
    logic [ACC_W:0]           sum;

    assign in_beat   = i_in.valid && i_in.ready;
    assign pos_start = in_beat && !i_in.data.action;
    assign in_range  = {1'b0, r_read_index} < RD_LIMIT;
    assign pos_idx_next = pos_idx + IW'(1);

    lba_pos #(.MAX_GRID(MAX_GRID)) u_pos (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (pos_start),
        .i_sample          (i_in.data.sample),
        .i_weight          (i_in.data.sample_weight),
        .i_drop            (i_in.data.is_infinite),
        .i_grid_start      (r_grid_start),
        .i_inverse_spacing (r_inverse_spacing),
        .i_grid_points     (r_grid_points),
        .o_status          (pos_st),
        .o_idx             (pos_idx),
        .o_amt_lead        (amt_lead),
        .o_amt_next        (amt_next)
    );

    lba_bank #(.DEPTH(MAX_GRID)) u_bank (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    always_comb begin
        amt_sel = (r_state == S_W1) ? amt_next : amt_lead;
        sum     = {1'b0, mem_rd_data} + {{(ACC_W+1-AMT_W){1'b0}}, amt_sel};
        sat_sum = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_beat) n_state = i_in.data.action ? S_RADDR : S_POS;
            end
            S_POS: begin
                if (pos_st.done) n_state = (pos_st.op == OP_NONE) ? S_IDLE : S_W0;
            end
            S_W0: begin
                n_state = (pos_st.op == OP_PAIR) ? S_W1 : S_IDLE;
            end
            S_W1: begin
                n_state = S_IDLE;
            end
            S_RADDR: begin
                if (!r_out_valid || o_out.ready) n_state = S_RDATA;
            end
            S_RDATA: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = pos_idx;
        mem_wr_en   = 1'b0;
        mem_wr_addr = pos_idx;
        mem_wr_data = '0;
        out_load    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr;
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
            end
            S_POS: begin
                mem_rd_en = pos_st.done && (pos_st.op != OP_NONE);
            end
            S_W0: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = sat_sum;
                mem_rd_en   = (pos_st.op == OP_PAIR);
                mem_rd_addr = pos_idx_next;
            end
            S_W1: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_idx_next;
                mem_wr_data = sat_sum;
            end
            S_RADDR: begin
                mem_rd_en   = in_range && (!r_out_valid || o_out.ready);
                mem_rd_addr = IW'(r_read_index);
            end
            S_RDATA: begin
                out_load    = 1'b1;
                mem_wr_en   = in_range;
                mem_wr_addr = IW'(r_read_index);
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) n_out_valid = 1'b0;
        if (out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_CLEAR;
            r_clr             <= '0;
            r_out_valid       <= 1'b0;
            r_grid_start      <= GRID_START_RST;
            r_inverse_spacing <= INVERSE_SPACING_RST;
            r_grid_points     <= GRID_POINTS_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) r_clr <= r_clr + IW'(1);
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_GRID_START:      r_grid_start      <= i_cfg_wr_data;
                    CFG_INVERSE_SPACING: r_inverse_spacing <= i_cfg_wr_data;
                    CFG_GRID_POINTS:     r_grid_points     <= i_cfg_wr_data[GP_W-1:0];
                    default:             r_grid_points     <= r_grid_points;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) r_read_index <= i_in.data.read_index;
        if (out_load) r_out_data <= in_range ? mem_rd_data : '0;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.data.bin_total = r_out_data;

    a_pos_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos_st.done |-> (r_state == S_POS))
        else $error("position result arrived outside its wait state");

    a_pair_second_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W1) |-> (mem_wr_addr != $past(mem_wr_addr)))
        else $error("second bin write hit the first bin");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDATA) |-> !r_out_valid)
        else $error("read result loaded over a pending beat");

endmodule
